>>> rtl/ttfe_pkg.sv
package ttfe_pkg;

  // Format codes held in the configuration register
  localparam logic [2:0] FMT_I4     = 3'd0;
  localparam logic [2:0] FMT_I8     = 3'd1;
  localparam logic [2:0] FMT_IA4    = 3'd2;
  localparam logic [2:0] FMT_IA8    = 3'd3;
  localparam logic [2:0] FMT_RGB565 = 3'd4;
  localparam logic [2:0] FMT_RGB5A3 = 3'd5;
  localparam logic [2:0] FMT_RGBA8  = 3'd6;

  // Q0.16 luminance weights
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // Opaque threshold for RGB5A3
  localparam logic [7:0] ALPHA_OPAQUE = 8'he0;

  // Last pixel slot of a 4x4 tile
  localparam logic [3:0] TILE_LAST = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LUMA,
    S_EMIT,
    S_FETCH,
    S_GB
  } ttfe_state_t;

  typedef enum logic [1:0] {
    SEL_BYTE0,
    SEL_BYTE1,
    SEL_GREEN,
    SEL_BLUE
  } ttfe_sel_t;

  typedef struct packed {
    logic       cap;
    logic       mul;
    logic       luma;
    logic       load;
    ttfe_sel_t  sel;
    logic       last;
    logic [3:0] rd_addr;
  } ttfe_cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic [1:0] nbytes;
    logic       flush;
  } ttfe_sts_t;

endpackage

>>> rtl/tiled_texel_format_encoder.sv
// Channel  Ports                                        Direction
// config   cfg_we, cfg_data[2:0]                        in
// pixel    in_valid, in_stall, in_red/green/blue/alpha  in
// byte     out_valid, out_stall, out_data_byte, out_run_last  out
//
// A pixel passes through capture, weight products, and luminance and byte build,
// then emits its bytes one at a time, or emits none.
// The RGBA8 tile flush then reads each of 16 stored entries, emitting G and B.
// A stall on the byte channel holds the sequencer in place at its current byte.
// Reset clears the state machine, the format and its counters; the G/B store
// is not cleared.
module tiled_texel_format_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_run_last
);
  import ttfe_pkg::*;

  ttfe_cmd_t cmd;
  ttfe_sts_t sts;

  // Sequencer
  ttfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, store and output register
  ttfe_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_run_last  (out_run_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

>>> rtl/ttfe_ctrl.sv
module ttfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttfe_pkg::ttfe_sts_t sts,
  output ttfe_pkg::ttfe_cmd_t cmd
);
  import ttfe_pkg::*;

  ttfe_state_t state_r, state_nxt;
  logic        idx_r, idx_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        half_r, half_nxt;
  logic        last_byte;

  // Last of the per-pixel bytes
  assign last_byte = (sts.nbytes == 2'd1) ? 1'b1 : idx_r;

  // Hold state and sequence counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 1'b0;
      k_r     <= 4'd0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      half_r  <= half_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    half_nxt  = half_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_LUMA;
      S_LUMA: begin
        state_nxt = S_EMIT;
        idx_nxt   = 1'b0;
      end
      S_EMIT: begin
        if (sts.nbytes == 2'd0) begin
          state_nxt = S_IDLE;
        end else if (sts.slot_free) begin
          if (last_byte) begin
            idx_nxt = 1'b0;
            if (sts.flush) begin
              state_nxt = S_FETCH;
              k_nxt     = 4'd0;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_GB;
        half_nxt  = 1'b0;
      end
      S_GB: begin
        if (sts.slot_free) begin
          if (half_r) begin
            half_nxt = 1'b0;
            if (k_r == TILE_LAST) begin
              state_nxt = S_IDLE;
              k_nxt     = 4'd0;
            end else begin
              state_nxt = S_FETCH;
              k_nxt     = k_r + 4'd1;
            end
          end else begin
            half_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.sel     = SEL_BYTE0;
    cmd.rd_addr = k_r;
    in_stall    = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd.cap = in_valid;
      S_MUL:  cmd.mul = 1'b1;
      S_LUMA: cmd.luma = 1'b1;
      S_EMIT: begin
        if (sts.nbytes != 2'd0 && sts.slot_free) begin
          cmd.load = 1'b1;
          cmd.sel  = idx_r ? SEL_BYTE1 : SEL_BYTE0;
          cmd.last = last_byte && !sts.flush;
        end
      end
      S_GB: begin
        if (sts.slot_free) begin
          cmd.load = 1'b1;
          cmd.sel  = half_r ? SEL_BLUE : SEL_GREEN;
          cmd.last = half_r && (k_r == TILE_LAST);
        end
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

>>> rtl/ttfe_dpath.sv
module ttfe_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_alpha,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_data_byte,
  output logic               out_run_last,
  input  ttfe_pkg::ttfe_cmd_t cmd,
  output ttfe_pkg::ttfe_sts_t sts
);
  import ttfe_pkg::*;

  logic [2:0]  fmt_r;
  logic [3:0]  held_r;
  logic        phase_r;
  logic [3:0]  cnt_r;
  logic [7:0]  r_r, g_r, b_r, a_r;
  logic [22:0] pr_r;
  logic [23:0] pg_r;
  logic [20:0] pb_r;
  logic [23:0] sum;
  logic [7:0]  luma;
  logic [7:0]  b0_nxt, b1_nxt, b0_r, b1_r;
  logic [1:0]  nb_nxt, nb_r;
  logic        flush_r;
  logic [15:0] mem [16];
  logic [15:0] rd_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  // Capture the pixel
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      r_r <= in_red;
      g_r <= in_green;
      b_r <= in_blue;
      a_r <= in_alpha;
    end
  end

  // Weighted products for luminance
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pr_r <= {8'd0, W_RED[14:0]} * {15'd0, r_r};
      pg_r <= {8'd0, W_GREEN} * {16'd0, g_r};
      pb_r <= {8'd0, W_BLUE[12:0]} * {13'd0, b_r};
    end
  end

  assign sum  = pg_r + {1'b0, pr_r} + {3'b000, pb_r};
  assign luma = sum[23:16];

  // Build the bytes for this pixel
  always_comb begin
    b0_nxt = 8'h00;
    b1_nxt = 8'h00;
    nb_nxt = 2'd0;
    case (fmt_r)
      FMT_I4: begin
        b0_nxt = {held_r, luma[7:4]};
        nb_nxt = phase_r ? 2'd1 : 2'd0;
      end
      FMT_I8: begin
        b0_nxt = luma;
        nb_nxt = 2'd1;
      end
      FMT_IA4: begin
        b0_nxt = {luma[7:4], a_r[7:4]};
        nb_nxt = 2'd1;
      end
      FMT_IA8: begin
        b0_nxt = luma;
        b1_nxt = a_r;
        nb_nxt = 2'd2;
      end
      FMT_RGB565: begin
        b0_nxt = {r_r[7:3], g_r[7:5]};
        b1_nxt = {g_r[4:2], b_r[7:3]};
        nb_nxt = 2'd2;
      end
      FMT_RGB5A3: begin
        if (a_r < ALPHA_OPAQUE) begin
          b0_nxt = {1'b0, a_r[7:5], r_r[7:4]};
          b1_nxt = {g_r[7:4], b_r[7:4]};
        end else begin
          b0_nxt = {1'b1, r_r[7:3], g_r[7:6]};
          b1_nxt = {g_r[5:3], b_r[7:3]};
        end
        nb_nxt = 2'd2;
      end
      FMT_RGBA8: begin
        b0_nxt = a_r;
        b1_nxt = r_r;
        nb_nxt = 2'd2;
      end
      default: nb_nxt = 2'd0;
    endcase
  end

  // Register the pixel's bytes
  always_ff @(posedge clk) begin
    if (cmd.luma) begin
      b0_r    <= b0_nxt;
      b1_r    <= b1_nxt;
      nb_r    <= nb_nxt;
      flush_r <= (fmt_r == FMT_RGBA8) && (cnt_r == TILE_LAST);
    end
  end

  // Format register and format counters; a write clears the counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_I4;
      held_r  <= 4'd0;
      phase_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else if (cfg_we) begin
      fmt_r   <= cfg_data;
      held_r  <= 4'd0;
      phase_r <= 1'b0;
      cnt_r   <= 4'd0;
    end else if (cmd.luma) begin
      if (fmt_r == FMT_I4) begin
        if (!phase_r) held_r <= luma[7:4];
        phase_r <= !phase_r;
      end
      if (fmt_r == FMT_RGBA8) cnt_r <= cnt_r + 4'd1;
    end
  end

  // Green/blue store for the tile
  always_ff @(posedge clk) begin
    if (cmd.mul && fmt_r == FMT_RGBA8) mem[cnt_r] <= {g_r, b_r};
    rd_r <= mem[cmd.rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.sel)
        SEL_BYTE0: out_byte_r <= b0_r;
        SEL_BYTE1: out_byte_r <= b1_r;
        SEL_GREEN: out_byte_r <= rd_r[15:8];
        SEL_BLUE:  out_byte_r <= rd_r[7:0];
        default:   out_byte_r <= b0_r;
      endcase
      out_last_r <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_run_last  = out_last_r;

  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.nbytes    = nb_r;
  assign sts.flush     = flush_r;

endmodule
